// File: hdl/dpf_pkg.sv
// Package for the data packet framer: shared constants, step codes and the
// hex digit function. No dependencies.
package dpf_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 256;

    localparam int unsigned LEN_IN_W = 9;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned STEP_W   = 5;

    localparam logic MODE_HEADER = 1'b0;
    localparam logic MODE_DATA   = 1'b1;

    localparam logic [7:0] TYPE_BYTE = 8'h02;
    localparam logic [7:0] FLAG_CHAR = 8'h31;
    localparam logic [7:0] ZERO_CHAR = 8'h30;
    localparam logic [7:0] ALPHA_A   = 8'h41;

    localparam logic [WORD_W-1:0] LEN_BIAS = 16'd8;

    // header steps
    localparam logic [STEP_W-1:0] STEP_TYPE    = 5'd0;
    localparam logic [STEP_W-1:0] STEP_SUB_HI  = 5'd1;
    localparam logic [STEP_W-1:0] STEP_SUB_LO  = 5'd2;
    localparam logic [STEP_W-1:0] STEP_FLAG    = 5'd3;
    localparam logic [STEP_W-1:0] STEP_HDR_END = 5'd15;
    localparam logic [STEP_W-1:0] STEP_HDR_CHI = 5'd16;
    // data steps
    localparam logic [STEP_W-1:0] STEP_DATA    = 5'd0;
    localparam logic [STEP_W-1:0] STEP_DAT_CHI = 5'd1;

    // hex word groups within header steps, picked by step[4:2]
    localparam logic [2:0] GRP_LEN    = 3'd1;
    localparam logic [2:0] GRP_TOTAL  = 3'd2;
    localparam logic [2:0] GRP_NUMBER = 3'd3;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] v;
        v = {4'd0, nib};
        hex_char = (nib < 4'd10) ? (ZERO_CHAR + v) : (ALPHA_A + v - 8'd10);
    endfunction

endpackage

// File: hdl/data_packet_framer_unit.sv
// Data packet framer top level: input register, result sequencer, output register.
// Depends on dpf_pkg.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+----------------------------------------------
//  input   | i_valid | o_stall | i_mode, i_subtype_chars, i_total_packets,
//          |         |         | i_packet_number, i_payload_length, i_data_byte
//  output  | o_valid | i_stall | o_out_byte, o_packet_end, o_run_last,
//          |         |         | o_sequence_error
//
// One result byte leaves per cycle while the output is not stalled; an item
// has one result per step: header 16 or 18, data byte 1 or 3, stray byte 1.
// The step counter over the held item sets this. The next item loads in the
// cycle its predecessor's last result enters the output register. Reset
// (synchronous, active low) closes any packet and empties both registers.
// Output stalls hold the result register and pause the step counter.
module data_packet_framer_unit #(
    parameter int unsigned MAX_PAYLOAD = dpf_pkg::MAX_PAYLOAD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [15:0] i_subtype_chars,
    input  logic [15:0] i_total_packets,
    input  logic [15:0] i_packet_number,
    input  logic [8:0]  i_payload_length,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_packet_end,
    output logic        o_run_last,
    output logic        o_sequence_error
);

    localparam int unsigned LW = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned WW = dpf_pkg::WORD_W;
    localparam int unsigned SW = dpf_pkg::STEP_W;
    localparam logic [WW-1:0] MAX_LEN = WW'(MAX_PAYLOAD);

    // held item
    logic          r_busy;
    logic [SW-1:0] r_step;
    logic          r_mode;
    logic [15:0]   r_sub;
    logic [15:0]   r_total;
    logic [15:0]   r_number;
    logic [WW-1:0] r_len;
    logic [7:0]    r_data;

    // packet state
    logic          r_open;
    logic [LW-1:0] r_rem;
    logic [7:0]    r_sum;
    logic          r_herr;
    logic          n_open;
    logic [LW-1:0] n_rem;
    logic [7:0]    n_sum;
    logic          n_herr;

    // result register
    logic          r_ov;
    logic [7:0]    r_byte;
    logic          r_end;
    logic          r_last;
    logic          r_err;

    logic          adv;
    logic          load;
    logic [7:0]    s_byte;
    logic          s_end;
    logic          s_last;
    logic          s_err;
    logic [7:0]    chk;
    logic [WW-1:0] len_in;
    logic [WW-1:0] len_sat;
    logic [WW-1:0] word;
    logic [3:0]    nib;
    logic [LW-1:0] rem_dec;

    assign adv     = r_busy && (!r_ov || !i_stall);
    assign o_stall = r_busy && !(adv && s_last);
    assign load    = i_valid && !o_stall;

    assign len_in  = WW'(i_payload_length);
    assign len_sat = (len_in > MAX_LEN) ? MAX_LEN : len_in;
    assign chk     = 8'd0 - r_sum;
    assign rem_dec = (r_rem != '0) ? (r_rem - LW'(1)) : '0;

    always_comb begin
        unique case (r_step[4:2])
            dpf_pkg::GRP_LEN:    word = r_len + dpf_pkg::LEN_BIAS;
            dpf_pkg::GRP_TOTAL:  word = r_total;
            dpf_pkg::GRP_NUMBER: word = r_number;
            default:             word = r_number;
        endcase
        unique case (r_step[1:0])
            2'd0:    nib = word[15:12];
            2'd1:    nib = word[11:8];
            2'd2:    nib = word[7:4];
            default: nib = word[3:0];
        endcase
    end

    always_comb begin
        s_byte = '0;
        s_end  = 1'b0;
        s_last = 1'b0;
        s_err  = 1'b0;
        n_open = r_open;
        n_rem  = r_rem;
        n_sum  = r_sum;
        n_herr = r_herr;
        if (r_mode == dpf_pkg::MODE_HEADER) begin
            s_err = (r_step == dpf_pkg::STEP_TYPE) ? r_open : r_herr;
            if (r_step == dpf_pkg::STEP_TYPE) begin
                s_byte = dpf_pkg::TYPE_BYTE;
                n_sum  = '0;
                n_herr = r_open;
                n_open = 1'b1;
                n_rem  = r_len[LW-1:0];
            end else if (r_step <= dpf_pkg::STEP_HDR_END) begin
                unique case (r_step)
                    dpf_pkg::STEP_SUB_HI: s_byte = r_sub[15:8];
                    dpf_pkg::STEP_SUB_LO: s_byte = r_sub[7:0];
                    dpf_pkg::STEP_FLAG:   s_byte = dpf_pkg::FLAG_CHAR;
                    default:              s_byte = dpf_pkg::hex_char(nib);
                endcase
                n_sum  = r_sum + s_byte;
                s_last = (r_step == dpf_pkg::STEP_HDR_END) && (r_rem != '0);
            end else if (r_step == dpf_pkg::STEP_HDR_CHI) begin
                s_byte = dpf_pkg::hex_char(chk[7:4]);
            end else begin
                s_byte = dpf_pkg::hex_char(chk[3:0]);
                s_end  = 1'b1;
                s_last = 1'b1;
                n_open = 1'b0;
                n_rem  = '0;
                n_sum  = '0;
            end
        end else begin
            if (r_step == dpf_pkg::STEP_DATA) begin
                if (!r_open) begin
                    // stray byte: dropped, flagged, no state change
                    s_last = 1'b1;
                    s_err  = 1'b1;
                end else begin
                    s_byte = r_data;
                    n_sum  = r_sum + r_data;
                    n_rem  = rem_dec;
                    s_last = (rem_dec != '0);
                end
            end else if (r_step == dpf_pkg::STEP_DAT_CHI) begin
                s_byte = dpf_pkg::hex_char(chk[7:4]);
            end else begin
                s_byte = dpf_pkg::hex_char(chk[3:0]);
                s_end  = 1'b1;
                s_last = 1'b1;
                n_open = 1'b0;
                n_rem  = '0;
                n_sum  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_open <= 1'b0;
            r_rem  <= '0;
            r_sum  <= '0;
            r_herr <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (adv) begin
                r_busy <= !s_last;
                r_step <= r_step + SW'(1);
            end
            if (adv) begin
                r_open <= n_open;
                r_rem  <= n_rem;
                r_sum  <= n_sum;
                r_herr <= n_herr;
                r_ov   <= 1'b1;
            end else if (!i_stall) begin
                r_ov   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_mode   <= i_mode;
            r_sub    <= i_subtype_chars;
            r_total  <= i_total_packets;
            r_number <= i_packet_number;
            r_len    <= len_sat;
            r_data   <= i_data_byte;
        end
        if (adv) begin
            r_byte <= s_byte;
            r_end  <= s_end;
            r_last <= s_last;
            r_err  <= s_err;
        end
    end

    assign o_valid          = r_ov;
    assign o_out_byte       = r_byte;
    assign o_packet_end     = r_end;
    assign o_run_last       = r_last;
    assign o_sequence_error = r_err;

endmodule
